### rtl/mono_fb_to_rgba_writer_assert.svh
// Assertion macros used by the RTL file that checks itself.
// Both macros sample on the rising edge of clk and are off during reset.
`ifndef MONO_FB_TO_RGBA_WRITER_ASSERT_SVH
`define MONO_FB_TO_RGBA_WRITER_ASSERT_SVH
`ifndef SYNTH
// A condition that holds in the same cycle.
`define MFR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// A condition that holds in the cycle after the trigger.
`define MFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MFR_ASSERT_NOW(lbl, ante, cons)
`define MFR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/mfr_pkg.sv
package mfr_pkg;

  // Source framebuffer geometry.
  localparam int WORD_BITS       = 16;
  localparam int SRC_LINE_PIXELS = 512;
  localparam int FB_ADDR_W       = 13;

  // One lane colors two pixels, so a source word spreads over this many lanes.
  localparam int LANES  = WORD_BITS / 2;
  localparam int BEAT_W = $clog2(LANES);

  // Pixel index split into x and y.
  localparam int PIX_SH = $clog2(WORD_BITS);
  localparam int PIX_W  = FB_ADDR_W + PIX_SH;
  localparam int SRC_SH = $clog2(SRC_LINE_PIXELS);

  // Item commands.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ENABLE        = 3'd0,
    REG_FRAME_BASE    = 3'd1,
    REG_FRAME_WIDTH   = 3'd2,
    REG_FRAME_HEIGHT  = 3'd3,
    REG_WINDOW_ORIGIN = 3'd4,
    REG_WINDOW_SIZE   = 3'd5,
    REG_BACK_COLOR    = 3'd6,
    REG_FORE_COLORS   = 3'd7
  } cfg_idx_t;

  // Pixel pairs of one source word, lane 0 in the low slot.
  typedef logic [LANES-1:0][63:0] pair_vec_t;

  // Position and classification of the next clear sweep word.
  typedef struct packed {
    logic        empty;
    logic [10:0] row;
    logic [9:0]  col;
    logic [9:0]  wpr;
    logic        in_win;
    logic        done;
  } sweep_info_t;

  // Word held between the first stage and the output stage.
  typedef struct packed {
    logic        is_clear;
    logic        clear_done;
    logic [27:0] prod;
    logic [16:0] lin;
    logic [31:0] fill;
  } s1_item_t;

endpackage

### rtl/mfr_lane.sv
module mfr_lane
  import mfr_pkg::*;
(
  input  logic        clk,
  input  logic        load,
  input  logic [1:0]  bits,
  input  logic [31:0] color0,
  input  logic [31:0] color1,
  output logic [63:0] pair_r
);

  // Color the left and right pixel of this lane and hold the pair.
  always_ff @(posedge clk) begin
    if (load) begin
      pair_r[31:0]  <= bits[0] ? color1 : color0;
      pair_r[63:32] <= bits[1] ? color1 : color0;
    end
  end

endmodule

### rtl/mfr_sweep.sv
module mfr_sweep
  import mfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [10:0] frame_width,
  input  logic [10:0] frame_height,
  input  logic [31:0] window_origin,
  input  logic [31:0] window_size,
  output sweep_info_t info
);

  logic [10:0] sweep_row_r;
  logic [9:0]  sweep_col_r;
  logic [10:0] sweep_row_nxt;
  logic [9:0]  sweep_col_nxt;

  logic [9:0]  wpr;
  logic [10:0] row_w;
  logic [9:0]  col_w;
  logic [9:0]  col_inc;
  logic [10:0] row_inc;
  logic        done;
  logic        in_win;

  assign wpr = frame_width[10:1];

  // Wrap a stale position, then advance one word along the row.
  always_comb begin
    row_w = sweep_row_r;
    col_w = sweep_col_r;
    if (col_w >= wpr) begin
      col_w = '0;
      row_w = row_w + 11'd1;
    end
    if (row_w >= frame_height) begin
      row_w = '0;
    end

    col_inc = col_w + 10'd1;
    row_inc = row_w;
    done    = 1'b0;
    if (col_inc >= wpr) begin
      col_inc = '0;
      row_inc = row_w + 11'd1;
      if (row_inc >= frame_height) begin
        row_inc = '0;
        done    = 1'b1;
      end
    end
  end

  // The word is in the window when both its row and column fall in range.
  always_comb begin
    in_win = ({5'd0, row_w} >= window_origin[31:16]) &&
             ({6'd0, row_w} < ({1'b0, window_origin[31:16]} + {1'b0, window_size[31:16]})) &&
             ({5'd0, col_w} >= window_origin[15:1]) &&
             ({6'd0, col_w} < ({1'b0, window_origin[15:1]} + {1'b0, window_size[15:1]}));
  end

  assign info.empty  = (wpr == '0) || (frame_height == '0);
  assign info.row    = row_w;
  assign info.col    = col_w;
  assign info.wpr    = wpr;
  assign info.in_win = in_win;
  assign info.done   = done;

  // An empty frame parks the sweep at the origin.
  always_comb begin
    sweep_row_nxt = sweep_row_r;
    sweep_col_nxt = sweep_col_r;
    if (step) begin
      if (info.empty) begin
        sweep_row_nxt = '0;
        sweep_col_nxt = '0;
      end else begin
        sweep_row_nxt = row_inc;
        sweep_col_nxt = col_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_row_r <= '0;
      sweep_col_r <= '0;
    end else begin
      sweep_row_r <= sweep_row_nxt;
      sweep_col_r <= sweep_col_nxt;
    end
  end

endmodule

### rtl/mfr_merge.sv
module mfr_merge
  import mfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s1_valid,
  input  s1_item_t    s1_item,
  input  pair_vec_t   lane_pairs,
  input  logic [31:0] frame_base,
  output logic        s2_load,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [28:0] out_word_addr,
  output logic [63:0] out_pixel_pair,
  output logic        out_last_of_run,
  output logic        out_clear_done
);

  logic              o_v_r;
  logic [BEAT_W-1:0] beat_r;
  logic [28:0]       addr_r;
  logic              clear_r;
  logic              done_r;
  logic [31:0]       fill_r;
  pair_vec_t         pairs_r;

  logic        fire;
  logic        last;
  logic [29:0] sum;
  logic [31:0] byte_addr;
  logic [28:0] load_addr;

  assign fire = o_v_r && !out_stall;
  assign last = clear_r || (beat_r == BEAT_W'(LANES - 1));
  assign s2_load = !o_v_r || (fire && last);

  // Final DRAM address of the first word of the incoming item.
  always_comb begin
    sum       = 30'(s1_item.prod) + 30'(s1_item.lin);
    byte_addr = {sum, 2'b00} + frame_base;
    if (s1_item.is_clear) begin
      load_addr = frame_base[31:3] + 29'(s1_item.prod) + 29'(s1_item.lin);
    end else begin
      load_addr = byte_addr[31:3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r  <= 1'b0;
      beat_r <= '0;
    end else if (s2_load) begin
      o_v_r  <= s1_valid;
      beat_r <= '0;
    end else if (fire) begin
      beat_r <= beat_r + BEAT_W'(1);
    end
  end

  // Payload: capture a new item, or step the address on each sent word.
  always_ff @(posedge clk) begin
    if (s2_load) begin
      addr_r  <= load_addr;
      clear_r <= s1_item.is_clear;
      done_r  <= s1_item.clear_done;
      fill_r  <= s1_item.fill;
      pairs_r <= lane_pairs;
    end else if (fire) begin
      addr_r <= addr_r + 29'd1;
    end
  end

  assign out_valid       = o_v_r;
  assign out_word_addr   = addr_r;
  assign out_pixel_pair  = clear_r ? {fill_r, fill_r} : pairs_r[beat_r];
  assign out_last_of_run = last;
  assign out_clear_done  = clear_r && done_r;

endmodule

### rtl/mono_fb_to_rgba_writer.sv
// Converts 1-bit-per-pixel source words into RGBA DRAM writes. A write item
// (cmd 0) is colored by eight parallel lanes and then leaves the output
// register as eight 64-bit words, one per cycle while out_stall is low; a
// clear item (cmd 1) gives one word, or none when the frame is empty. The
// output serializer sets the sustained rate: one word per cycle as long as
// out_stall is low. An accepted item is registered in the first stage and
// then in the output register, and the next item is taken while the current
// one drains. While enable is 0 items are still taken but are dropped without
// any word. Write the configuration only while no word is pending.
`include "mono_fb_to_rgba_writer_assert.svh"

module mono_fb_to_rgba_writer
  import mfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [63:0]          cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_cmd,
  input  logic [FB_ADDR_W-1:0] in_fb_addr,
  input  logic [15:0]          in_fb_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [28:0]          out_word_addr,
  output logic [63:0]          out_pixel_pair,
  output logic                 out_last_of_run,
  output logic                 out_clear_done
);

  logic        enable_r;
  logic [31:0] frame_base_r;
  logic [10:0] frame_width_r;
  logic [10:0] frame_height_r;
  logic [31:0] window_origin_r;
  logic [31:0] window_size_r;
  logic [31:0] back_color_r;
  logic [63:0] fore_colors_r;

  logic        s1_v_r;
  s1_item_t    s1_r;
  s1_item_t    s1_nxt;
  logic        s2_load;
  logic        in_fire;
  logic        s1_load;
  logic        sweep_step;
  logic        lane_load;
  sweep_info_t sw;
  pair_vec_t   lane_pairs;

  logic [PIX_W-1:0]        pix;
  logic [SRC_SH-1:0]       src_x;
  logic [PIX_W-SRC_SH-1:0] src_y;
  logic [10:0]             mul_a;
  logic [16:0]             mul_b;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r        <= 1'b0;
      frame_base_r    <= '0;
      frame_width_r   <= '0;
      frame_height_r  <= '0;
      window_origin_r <= '0;
      window_size_r   <= '0;
      back_color_r    <= '0;
      fore_colors_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_ENABLE:        enable_r        <= cfg_wdata[0];
        REG_FRAME_BASE:    frame_base_r    <= cfg_wdata[31:0];
        REG_FRAME_WIDTH:   frame_width_r   <= cfg_wdata[10:0];
        REG_FRAME_HEIGHT:  frame_height_r  <= cfg_wdata[10:0];
        REG_WINDOW_ORIGIN: window_origin_r <= cfg_wdata[31:0];
        REG_WINDOW_SIZE:   window_size_r   <= cfg_wdata[31:0];
        REG_BACK_COLOR:    back_color_r    <= cfg_wdata[31:0];
        REG_FORE_COLORS:   fore_colors_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input handshake: the first stage moves whenever the output takes its word.
  assign in_stall   = s1_v_r && !s2_load;
  assign in_fire    = in_valid && !in_stall;
  assign sweep_step = in_fire && enable_r && (in_cmd == CMD_CLEAR);
  assign lane_load  = in_fire && (in_cmd == CMD_WRITE);
  assign s1_load    = in_fire && enable_r && ((in_cmd == CMD_WRITE) || !sw.empty);

  // Clear sweep position.
  mfr_sweep u_sweep (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (sweep_step),
    .frame_width   (frame_width_r),
    .frame_height  (frame_height_r),
    .window_origin (window_origin_r),
    .window_size   (window_size_r),
    .info          (sw)
  );

  // Coloring lanes, two source pixels each.
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    mfr_lane u_lane (
      .clk    (clk),
      .load   (lane_load),
      .bits   (in_fb_data[2*g +: 2]),
      .color0 (fore_colors_r[31:0]),
      .color1 (fore_colors_r[63:32]),
      .pair_r (lane_pairs[g])
    );
  end

  // Source pixel position of the word.
  assign pix   = {in_fb_addr, PIX_SH'(0)};
  assign src_x = pix[SRC_SH-1:0];
  assign src_y = pix[PIX_W-1:SRC_SH];

  // One shared multiplier: line offset for writes, row offset for clears.
  always_comb begin
    if (in_cmd == CMD_CLEAR) begin
      mul_a = sw.row;
      mul_b = 17'(sw.wpr);
      s1_nxt.lin = 17'(sw.col);
      s1_nxt.fill = sw.in_win ? fore_colors_r[31:0] : back_color_r;
    end else begin
      mul_a = frame_width_r;
      mul_b = {1'b0, window_origin_r[31:16]} + 17'(src_y);
      s1_nxt.lin = {1'b0, window_origin_r[15:0]} + 17'(src_x);
      s1_nxt.fill = fore_colors_r[31:0];
    end
    s1_nxt.is_clear   = (in_cmd == CMD_CLEAR);
    s1_nxt.clear_done = (in_cmd == CMD_CLEAR) && sw.done;
    s1_nxt.prod       = 28'(mul_a * mul_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_load) begin
      s1_v_r <= 1'b1;
    end else if (s2_load) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
  end

  // Merge the lanes into the outgoing word sequence.
  mfr_merge u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .s1_valid        (s1_v_r),
    .s1_item         (s1_r),
    .lane_pairs      (lane_pairs),
    .frame_base      (frame_base_r),
    .s2_load         (s2_load),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_word_addr   (out_word_addr),
    .out_pixel_pair  (out_pixel_pair),
    .out_last_of_run (out_last_of_run),
    .out_clear_done  (out_clear_done)
  );

  // A frame clear completes only on a single-word run.
  `MFR_ASSERT_NOW(a_done_is_last, out_valid && out_clear_done, out_last_of_run)
  // Words of one write run go to consecutive addresses.
  `MFR_ASSERT_NEXT(a_run_consecutive, out_valid && !out_stall && !out_last_of_run,
                   out_valid && (out_word_addr == $past(out_word_addr) + 29'd1))
  // The input only waits behind a full first stage and a busy output.
  `MFR_ASSERT_NOW(a_stall_reason, in_stall, s1_v_r && out_valid)

endmodule

### dv/mono_fb_to_rgba_writer_tb.sv
`timescale 1ns / 100ps

module mono_fb_to_rgba_writer_tb;
  import mfr_pkg::*;

  localparam int MAX_CYCLES = 400000;

  // Shadow copy of the configuration registers.
  typedef struct packed {
    logic        enable;
    logic [31:0] base;
    logic [10:0] width;
    logic [10:0] height;
    logic [31:0] origin;
    logic [31:0] win_size;
    logic [31:0] back;
    logic [63:0] fore;
  } frame_setup_t;

  // One DRAM write word as it should leave the block.
  typedef struct packed {
    logic [28:0] addr;
    logic [63:0] pair;
    logic        last;
    logic        done;
  } dram_write_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [2:0]           cfg_index;
  logic [63:0]          cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_cmd;
  logic [FB_ADDR_W-1:0] in_fb_addr;
  logic [15:0]          in_fb_data;
  logic                 out_valid;
  logic                 out_stall;
  logic [28:0]          out_word_addr;
  logic [63:0]          out_pixel_pair;
  logic                 out_last_of_run;
  logic                 out_clear_done;

  frame_setup_t setup;
  int           fill_row = 0;
  int           fill_col = 0;
  dram_write_t  dram_writes_due[$];
  int           errors = 0;
  int           cycle_count = 0;
  bit           send_gaps;
  bit           recv_gaps;
  int           hold_off = 0;

  mono_fb_to_rgba_writer u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_fb_addr      (in_fb_addr),
    .in_fb_data      (in_fb_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_word_addr   (out_word_addr),
    .out_pixel_pair  (out_pixel_pair),
    .out_last_of_run (out_last_of_run),
    .out_clear_done  (out_clear_done)
  );

  always #10 clk = ~clk;

  // Work out the DRAM writes caused by one accepted input word.
  task automatic predict_dram_writes(logic cmd, logic [FB_ADDR_W-1:0] fb_addr,
                                     logic [15:0] fb_data);
    logic [16:0] pix;
    logic [63:0] lin;
    logic [31:0] byte_addr;
    logic [28:0] first;
    logic [31:0] color;
    int          per_row;
    int          y0, y1, x0, x1;
    int          i;
    bit          in_window;
    bit          done;
    dram_write_t w;
    if (!setup.enable) return;
    if (cmd == CMD_WRITE) begin
      // Source pixel index splits into x in the low 9 bits and y above.
      pix = {fb_addr, 4'b0000};
      lin = 64'(setup.width) * (64'(setup.origin[31:16]) + 64'(pix[16:9]))
            + 64'(setup.origin[15:0]) + 64'(pix[8:0]);
      byte_addr = 32'(lin * 4 + 64'(setup.base));
      first = byte_addr[31:3];
      for (i = 0; i < LANES; i++) begin
        w.addr = first + 29'(i);
        w.pair = {fb_data[2*i+1] ? setup.fore[63:32] : setup.fore[31:0],
                  fb_data[2*i]   ? setup.fore[63:32] : setup.fore[31:0]};
        w.last = (i == LANES - 1);
        w.done = 1'b0;
        dram_writes_due.push_back(w);
      end
    end else begin
      per_row = int'(setup.width[10:1]);
      if (per_row == 0 || setup.height == 0) begin
        // An empty frame gives nothing and restarts the sweep.
        fill_row = 0;
        fill_col = 0;
      end else begin
        // A position left over from a larger frame wraps first.
        if (fill_col >= per_row) begin
          fill_col = 0;
          fill_row++;
        end
        if (fill_row >= int'(setup.height)) fill_row = 0;
        y0 = int'(setup.origin[31:16]);
        y1 = y0 + int'(setup.win_size[31:16]);
        x0 = int'(setup.origin[15:1]);
        x1 = x0 + int'(setup.win_size[15:1]);
        in_window = fill_row >= y0 && fill_row < y1 && fill_col >= x0 && fill_col < x1;
        color = in_window ? setup.fore[31:0] : setup.back;
        w.addr = setup.base[31:3] + 29'(fill_row * per_row + fill_col);
        w.pair = {color, color};
        w.last = 1'b1;
        done = 1'b0;
        fill_col++;
        if (fill_col >= per_row) begin
          fill_col = 0;
          fill_row++;
          if (fill_row >= int'(setup.height)) begin
            fill_row = 0;
            done = 1'b1;
          end
        end
        w.done = done;
        dram_writes_due.push_back(w);
      end
    end
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Predict on every accepted input word and check every accepted output word.
  always @(posedge clk) begin
    dram_write_t w;
    if (rst_n) begin
      if (in_valid && !in_stall) predict_dram_writes(in_cmd, in_fb_addr, in_fb_data);
      if (out_valid && !out_stall) begin
        if (dram_writes_due.size() == 0) begin
          $display("%0t: unexpected word, expected none, got addr %h pair %h", $time,
                   out_word_addr, out_pixel_pair);
          errors++;
        end else begin
          w = dram_writes_due.pop_front();
          check_field("word_addr", 64'(w.addr), 64'(out_word_addr));
          check_field("pixel_pair", w.pair, out_pixel_pair);
          check_field("last_of_run", 64'(w.last), 64'(out_last_of_run));
          check_field("clear_done", 64'(w.done), 64'(out_clear_done));
        end
      end
    end
  end

  // Result side: a random stall before each word, plus an optional long hold-off.
  initial begin
    int pause;
    out_stall = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_off > 0) begin
        out_stall <= 1'b1;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end
      pause = recv_gaps ? $urandom_range(0, 7) : 0;
      if (pause > 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid && hold_off == 0);
    end
  end

  // Run limit.
  initial begin
    while (cycle_count < MAX_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("mono_fb_to_rgba_writer_tb: FAIL");
    $finish;
  end

  // Offer one input word after a random gap and hold it until it is taken.
  task automatic send_word(logic cmd, logic [FB_ADDR_W-1:0] addr, logic [15:0] data);
    int gap;
    gap = send_gaps ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= cmd;
    in_fb_addr <= addr;
    in_fb_data <= data;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering words and wait until every expected word has come out.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (dram_writes_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Program all registers once the block has gone quiet.
  task automatic load_setup(frame_setup_t s);
    settle();
    write_reg(REG_ENABLE, 64'(s.enable));
    write_reg(REG_FRAME_BASE, 64'(s.base));
    write_reg(REG_FRAME_WIDTH, 64'(s.width));
    write_reg(REG_FRAME_HEIGHT, 64'(s.height));
    write_reg(REG_WINDOW_ORIGIN, 64'(s.origin));
    write_reg(REG_WINDOW_SIZE, 64'(s.win_size));
    write_reg(REG_BACK_COLOR, 64'(s.back));
    write_reg(REG_FORE_COLORS, s.fore);
    cfg_we <= 1'b0;
    setup = s;
  endtask

  function automatic frame_setup_t random_setup(int kind);
    frame_setup_t s;
    s.enable = 1'b1;
    s.base   = $urandom;
    s.back   = $urandom;
    s.fore   = {$urandom, $urandom};
    case (kind)
      0: begin
        // Tiny frame, so clear sweeps wrap around often.
        s.width    = 11'($urandom_range(0, 10));
        s.height   = 11'($urandom_range(0, 3));
        s.origin   = {16'($urandom_range(0, 3)), 16'($urandom_range(0, 10))};
        s.win_size = {16'($urandom_range(0, 3)), 16'($urandom_range(0, 10))};
      end
      1: begin
        s.width    = 11'($urandom);
        s.height   = 11'($urandom);
        s.origin   = $urandom;
        s.win_size = $urandom;
      end
      default: begin
        // Each field at one end of its range.
        s.base     = $urandom_range(0, 1) ? '1 : '0;
        s.width    = $urandom_range(0, 1) ? '1 : '0;
        s.height   = $urandom_range(0, 1) ? '1 : '0;
        s.origin   = $urandom_range(0, 1) ? '1 : '0;
        s.win_size = $urandom_range(0, 1) ? '1 : '0;
        s.back     = $urandom_range(0, 1) ? '1 : '0;
        s.fore     = $urandom_range(0, 1) ? '1 : '0;
      end
    endcase
    return s;
  endfunction

  // Right after reset the block is disabled, so every word is dropped.
  task automatic test_disabled_drop();
    send_word(CMD_WRITE, 13'h0a5, 16'hbeef);
    send_word(CMD_CLEAR, '0, '0);
    send_word(CMD_WRITE, '1, '1);
    send_word(CMD_CLEAR, '1, '1);
    settle();
  endtask

  // Extreme addresses and pixel patterns; the byte address wraps at 32 bits.
  task automatic test_write_extremes();
    load_setup('{1'b1, 32'hffff_fff8, 11'h7ff, 11'h7ff, 32'hffff_ffff, 32'hffff_ffff,
                 32'h1234_5678, 64'hffff_ffff_0000_0000});
    send_word(CMD_WRITE, '0, 16'h0000);
    send_word(CMD_WRITE, '1, 16'hffff);
    send_word(CMD_WRITE, 13'd31, 16'haaaa);
    send_word(CMD_WRITE, 13'd32, 16'h5555);
    send_word(CMD_CLEAR, '0, '0);
  endtask

  // A full sweep of a small frame with an odd width, then one word past the end.
  task automatic test_clear_sweep();
    int n;
    load_setup('{1'b1, 32'h0000_0048, 11'd7, 11'd3, {16'd1, 16'd2}, {16'd1, 16'd4},
                 32'h8040_2010, 64'h0f0f_0f0f_c0c0_c0c0});
    for (n = 0; n < 10; n++) send_word(CMD_CLEAR, 13'($urandom), 16'($urandom));
  endtask

  // A sweep position beyond a shrunk frame, then empty frames.
  task automatic test_stale_and_empty();
    int n;
    load_setup('{1'b1, 32'h0000_1000, 11'd16, 11'd4, {16'd0, 16'd4}, {16'd2, 16'd6},
                 32'h0102_0304, 64'haaaa_aaaa_5555_5555});
    for (n = 0; n < 5; n++) send_word(CMD_CLEAR, '0, '0);
    load_setup('{1'b1, 32'h0000_1000, 11'd6, 11'd1, {16'd0, 16'd0}, {16'd1, 16'd2},
                 32'h0102_0304, 64'haaaa_aaaa_5555_5555});
    send_word(CMD_CLEAR, '0, '0);
    send_word(CMD_CLEAR, '0, '0);
    load_setup('{1'b1, 32'h0000_1000, 11'd1, 11'd5, '0, '0, 32'h0102_0304, '0});
    send_word(CMD_CLEAR, '0, '0);
    load_setup('{1'b1, 32'h0000_1000, 11'd12, 11'd0, '0, '0, 32'h0102_0304, '0});
    send_word(CMD_CLEAR, '0, '0);
    load_setup('{1'b1, 32'h0000_1000, 11'd12, 11'd2, '0, {16'd1, 16'd2},
                 32'h0102_0304, 64'h7777_7777_3333_3333});
    send_word(CMD_CLEAR, '0, '0);
  endtask

  // The receiver holds off for a long time while words keep coming.
  task automatic test_backpressure();
    int n;
    load_setup(random_setup(1));
    send_gaps = 1'b0;
    hold_off  = 200;
    for (n = 0; n < 12; n++) send_word(CMD_WRITE, 13'($urandom), 16'($urandom));
    settle();
    send_gaps = 1'b1;
  endtask

  // Random words under a series of random setups.
  task automatic test_random_traffic();
    int          p;
    int          n;
    frame_setup_t s;
    logic        cmd;
    for (p = 0; p < 9; p++) begin
      s = random_setup(p % 3);
      if (p == 4) s.enable = 1'b0;
      load_setup(s);
      send_gaps = (p % 3 != 2);
      recv_gaps = (p % 4 != 3);
      for (n = 0; n < 12; n++) begin
        cmd = ($urandom_range(0, 1) == 1) ? CMD_CLEAR : CMD_WRITE;
        send_word(cmd, 13'($urandom), 16'($urandom));
      end
    end
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = REG_ENABLE;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_cmd     = CMD_WRITE;
    in_fb_addr = '0;
    in_fb_data = '0;
    setup      = '0;
    send_gaps  = 1'b1;
    recv_gaps  = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_disabled_drop();
    test_write_extremes();
    test_clear_sweep();
    test_stale_and_empty();
    test_backpressure();
    test_random_traffic();
    settle();
    if (errors == 0) begin
      $display("mono_fb_to_rgba_writer_tb: PASS");
    end else begin
      $display("mono_fb_to_rgba_writer_tb: FAIL");
    end
    $finish;
  end

endmodule
